// ===== hdl/ordered_handle_queue_defines.svh =====
// Assertion macros for the ordered handle queue.
// Uses clk and rst_n of the module that expands them.
`ifndef ORDERED_HANDLE_QUEUE_DEFINES_SVH
`define ORDERED_HANDLE_QUEUE_DEFINES_SVH

`ifndef SYNTH
`define OHQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ordered_handle_queue assertion failed");
`define OHQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ordered_handle_queue assertion failed");
`else
`define OHQ_ASSERT(lbl, prop)
`define OHQ_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hdl/ohq_pkg.sv =====
`default_nettype none

package ohq_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int HANDLE_BITS_DEF = 16;
  localparam int DEPTH_MAX       = 256;

  // fixed port widths
  localparam int FIELD_BITS = 16;
  localparam int POS_BITS   = 4;
  localparam int COUNT_BITS = 5;
  localparam int PTR_BITS   = $clog2(DEPTH_MAX);

  typedef enum logic [1:0] {
    FN_APPEND = 2'd0,
    FN_INSERT = 2'd1,
    FN_READ   = 2'd2,
    FN_REMOVE = 2'd3
  } func_e_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t              op;
    logic [PTR_BITS-1:0]   ins_pos;
    logic [PTR_BITS-1:0]   rd_pos;
  } ctl_t;

endpackage

`default_nettype wire

// ===== hdl/ordered_handle_queue.sv =====
// Ordered handle queue: a bounded list of task handles held in a chain of
// DEPTH cells, slot 0 being the head.
// Input channel (in_valid/in_ready): in_func selects append at tail, insert
// before in_position, read at in_position, or remove the head. An insert at
// or past the tail appends. A full queue rejects append and insert.
// Result channel (out_valid/out_ready): exactly one result per request with
// the handle read or removed, a status, the new head handle, an empty flag
// and the count after the request.
// The result is registered on the edge that accepts the request.
// Throughput is one request per cycle while out_ready is high;
// every cell compares its index to the request position and loads, shifts
// or holds in that same cycle.
// When the receiver stalls, the held result stays in the output register and
// in_ready drops until it is taken.
// Reset empties the queue (count zero) and clears out_valid; the slot
// contents are not cleared and are never read before being written.
`default_nettype none

`include "ordered_handle_queue_defines.svh"

module ordered_handle_queue #(
  parameter int DEPTH       = ohq_pkg::DEPTH_DEF,
  parameter int HANDLE_BITS = ohq_pkg::HANDLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_func,
  input  wire logic [ohq_pkg::FIELD_BITS-1:0]    in_handle_in,
  input  wire logic [ohq_pkg::POS_BITS-1:0]      in_position,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [ohq_pkg::FIELD_BITS-1:0]    out_handle_out,
  output logic      [1:0]                        out_status,
  output logic      [ohq_pkg::FIELD_BITS-1:0]    out_head_handle,
  output logic                                   out_vacant,
  output logic      [ohq_pkg::COUNT_BITS-1:0]    out_count
);

  localparam int OW   = $clog2(DEPTH + 1);
  localparam int CW   = (OW > ohq_pkg::POS_BITS) ? OW : ohq_pkg::POS_BITS;
  localparam int KEEP = (HANDLE_BITS < ohq_pkg::FIELD_BITS) ? HANDLE_BITS
                                                             : ohq_pkg::FIELD_BITS;
  localparam logic [OW-1:0] FULL_OCC = OW'(DEPTH);

  logic                   in_fire;
  logic [OW-1:0]          occ_r;
  logic [OW-1:0]          occ_nxt;
  logic                   full;
  logic                   add_req;
  logic                   pos_in_range;
  ohq_pkg::func_e_t       func;
  ohq_pkg::status_e_t     status;
  ohq_pkg::cell_op_t      op;
  ohq_pkg::ctl_t          ctl;
  logic [ohq_pkg::PTR_BITS-1:0] ins_pos;
  logic [HANDLE_BITS-1:0] h_kept;
  logic [HANDLE_BITS-1:0] hout;
  logic [HANDLE_BITS-1:0] head_nxt;
  logic [HANDLE_BITS-1:0] rd_data;
  logic [HANDLE_BITS-1:0] slot_q [DEPTH];
  logic [HANDLE_BITS-1:0] rd_bus [DEPTH];
  logic [ohq_pkg::FIELD_BITS-1:0] hout_port;
  logic [ohq_pkg::FIELD_BITS-1:0] head_port;

  logic                           out_valid_r;
  logic [ohq_pkg::FIELD_BITS-1:0] out_handle_r;
  ohq_pkg::status_e_t             out_status_r;
  logic [ohq_pkg::FIELD_BITS-1:0] out_head_r;
  logic                           out_empty_r;
  logic [ohq_pkg::COUNT_BITS-1:0] out_count_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign func     = ohq_pkg::func_e_t'(in_func);
  assign full     = (occ_r == FULL_OCC);
  assign add_req  = (func == ohq_pkg::FN_APPEND) || (func == ohq_pkg::FN_INSERT);
  assign pos_in_range = (CW'(in_position) < CW'(occ_r));

  always_comb begin
    h_kept = '0;
    h_kept[KEEP-1:0] = in_handle_in[KEEP-1:0];
  end

  // read bus: OR of the single addressed cell
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_data = rd_data | rd_bus[i];
    end
  end

  always_comb begin
    op      = ohq_pkg::CELL_HOLD;
    status  = ohq_pkg::ST_OK;
    hout    = '0;
    occ_nxt = occ_r;
    ins_pos = ohq_pkg::PTR_BITS'(occ_r);
    unique case (func)
      ohq_pkg::FN_APPEND, ohq_pkg::FN_INSERT: begin
        if (full) begin
          status = ohq_pkg::ST_FULL;
        end else begin
          op      = ohq_pkg::CELL_INSERT;
          occ_nxt = occ_r + OW'(1);
          if (func == ohq_pkg::FN_INSERT && pos_in_range) begin
            ins_pos = ohq_pkg::PTR_BITS'(in_position);
          end
        end
      end
      ohq_pkg::FN_READ: begin
        if (pos_in_range) begin
          hout = rd_data;
        end else begin
          status = ohq_pkg::ST_MISSING;
        end
      end
      ohq_pkg::FN_REMOVE: begin
        if (occ_r == '0) begin
          status = ohq_pkg::ST_MISSING;
        end else begin
          hout    = slot_q[0];
          op      = ohq_pkg::CELL_POP;
          occ_nxt = occ_r - OW'(1);
        end
      end
      default: begin
        op = ohq_pkg::CELL_HOLD;
      end
    endcase
  end

  always_comb begin
    ctl.op      = in_fire ? op : ohq_pkg::CELL_HOLD;
    ctl.ins_pos = ins_pos;
    ctl.rd_pos  = ohq_pkg::PTR_BITS'(in_position);
  end

  // head after this request, taken from the cells' inputs
  always_comb begin
    if (occ_nxt == '0) begin
      head_nxt = '0;
    end else if (op == ohq_pkg::CELL_INSERT && ins_pos == '0) begin
      head_nxt = h_kept;
    end else if (op == ohq_pkg::CELL_POP) begin
      head_nxt = slot_q[1];
    end else begin
      head_nxt = slot_q[0];
    end
  end

  always_comb begin
    hout_port = '0;
    head_port = '0;
    hout_port[KEEP-1:0] = hout[KEEP-1:0];
    head_port[KEEP-1:0] = head_nxt[KEEP-1:0];
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [HANDLE_BITS-1:0] left_q;
    logic [HANDLE_BITS-1:0] right_q;
    if (g == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid
      assign left_q = slot_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_q = slot_q[g];
    end else begin : g_inner
      assign right_q = slot_q[g+1];
    end
    ohq_cell #(
      .INDEX       (g),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .handle  (h_kept),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (slot_q[g]),
      .rd_q    (rd_bus[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      occ_r       <= occ_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_handle_r <= hout_port;
      out_status_r <= status;
      out_head_r   <= head_port;
      out_empty_r  <= (occ_nxt == '0);
      out_count_r  <= ohq_pkg::COUNT_BITS'(occ_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_handle_out  = out_handle_r;
  assign out_status      = out_status_r;
  assign out_head_handle = out_head_r;
  assign out_vacant      = out_empty_r;
  assign out_count       = out_count_r;

  `OHQ_ASSERT(a_occ_bound, occ_r <= FULL_OCC)
  `OHQ_ASSERT(a_fire_gives_result, in_fire |=> out_valid_r)
  `OHQ_ASSERT(a_empty_matches_occ, out_valid_r |-> (out_empty_r == (occ_r == '0)))
  `OHQ_ASSERT(a_full_keeps_occ, (in_fire && full && add_req) |=> (occ_r == FULL_OCC))
  `OHQ_ASSERT(a_full_status, (out_valid_r && out_status_r == ohq_pkg::ST_FULL) |-> full)

endmodule

`default_nettype wire

// ===== hdl/ohq_cell.sv =====
`default_nettype none

module ohq_cell #(
  parameter int INDEX       = 0,
  parameter int HANDLE_BITS = ohq_pkg::HANDLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire ohq_pkg::ctl_t          ctl,
  input  wire logic [HANDLE_BITS-1:0] handle,
  input  wire logic [HANDLE_BITS-1:0] left_q,
  input  wire logic [HANDLE_BITS-1:0] right_q,
  output logic      [HANDLE_BITS-1:0] q,
  output logic      [HANDLE_BITS-1:0] rd_q
);

  localparam logic [ohq_pkg::PTR_BITS-1:0] IDX = ohq_pkg::PTR_BITS'(INDEX);

  logic [HANDLE_BITS-1:0] slot_r;
  logic [HANDLE_BITS-1:0] slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    case (ctl.op)
      ohq_pkg::CELL_INSERT: begin
        if (IDX == ctl.ins_pos) begin
          slot_nxt = handle;
        end else if (IDX > ctl.ins_pos) begin
          slot_nxt = left_q;
        end
      end
      ohq_pkg::CELL_POP: begin
        slot_nxt = right_q;
      end
      default: begin
        slot_nxt = slot_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign q    = slot_r;
  // only the addressed cell drives the read bus
  assign rd_q = (IDX == ctl.rd_pos) ? slot_r : '0;

endmodule

`default_nettype wire

// ===== test/ohq_checker.sv =====
module ohq_checker
  import ohq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            in_func,
  input  logic [FIELD_BITS-1:0] in_handle_in,
  input  logic [POS_BITS-1:0]   in_position,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [FIELD_BITS-1:0] out_handle_out,
  input  logic [1:0]            out_status,
  input  logic [FIELD_BITS-1:0] out_head_handle,
  input  logic                  out_vacant,
  input  logic [COUNT_BITS-1:0] out_count,
  output int                    outstanding,
  output int                    errors
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [FIELD_BITS-1:0] handle;
    status_e_t             status;
    logic [FIELD_BITS-1:0] head;
    logic                  empty;
    logic [COUNT_BITS-1:0] count;
  } queue_result_t;

  logic [FIELD_BITS-1:0] slot_mem [DEPTH_DEF];
  int unsigned           held;
  queue_result_t         queued_results [$];
  queue_result_t         want;
  int unsigned           cycle_no;

  initial begin
    errors = 0;
    outstanding = 0;
    held = 0;
    cycle_no = 0;
  end

  function automatic queue_result_t apply_request(func_e_t fn, logic [FIELD_BITS-1:0] h,
                                                  logic [POS_BITS-1:0] pos);
    queue_result_t r;
    int unsigned   at;
    int unsigned   i;
    r = '0;
    r.status = ST_OK;
    case (fn)
      FN_APPEND, FN_INSERT: begin
        if (held >= DEPTH_DEF) begin
          r.status = ST_FULL;
        end else begin
          // insert at or past the tail degenerates to an append
          at = (fn == FN_APPEND || pos >= held) ? held : pos;
          for (i = held; i > at; i--) slot_mem[i] = slot_mem[i-1];
          slot_mem[at] = h;
          held++;
        end
      end
      FN_READ: begin
        if (pos < held) r.handle = slot_mem[pos];
        else r.status = ST_MISSING;
      end
      default: begin
        if (held == 0) begin
          r.status = ST_MISSING;
        end else begin
          r.handle = slot_mem[0];
          for (i = 1; i < held; i++) slot_mem[i-1] = slot_mem[i];
          held--;
        end
      end
    endcase
    r.head  = (held != 0) ? slot_mem[0] : '0;
    r.empty = (held == 0);
    r.count = held[COUNT_BITS-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [FIELD_BITS-1:0] got,
                                 logic [FIELD_BITS-1:0] exp);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_no, what, got, exp);
    errors++;
  endtask

  always @(posedge clk) begin
    cycle_no++;
    if (!rst_n) begin
      held = 0;
      queued_results.delete();
    end else begin
      // check the result first: a request taken on this edge cannot be answered yet
      if (out_valid && out_ready) begin
        if (queued_results.size() == 0) begin
          report_mismatch("unexpected result transaction, handle", out_handle_out, '0);
        end else begin
          want = queued_results.pop_front();
          if (out_handle_out !== want.handle)
            report_mismatch("handle_out", out_handle_out, want.handle);
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_head_handle !== want.head)
            report_mismatch("head_handle", out_head_handle, want.head);
          if (out_vacant !== want.empty)
            report_mismatch("vacant", out_vacant, want.empty);
          if (out_count !== want.count)
            report_mismatch("count", out_count, want.count);
        end
      end
      if (in_valid && in_ready)
        queued_results.push_back(apply_request(func_e_t'(in_func), in_handle_in, in_position));
    end
    outstanding <= queued_results.size();
  end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import ohq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 150;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_func = FN_APPEND;
  logic [FIELD_BITS-1:0] in_handle_in = '0;
  logic [POS_BITS-1:0]   in_position = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [FIELD_BITS-1:0] out_handle_out;
  logic [1:0]            out_status;
  logic [FIELD_BITS-1:0] out_head_handle;
  logic                  out_vacant;
  logic [COUNT_BITS-1:0] out_count;
  int                    outstanding;
  int                    errors;

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int unsigned cycles = 0;

  ordered_handle_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_func), .in_handle_in(in_handle_in), .in_position(in_position),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_handle_out(out_handle_out), .out_status(out_status),
    .out_head_handle(out_head_handle), .out_vacant(out_vacant),
    .out_count(out_count)
  );

  ohq_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_func), .in_handle_in(in_handle_in), .in_position(in_position),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_handle_out(out_handle_out), .out_status(out_status),
    .out_head_handle(out_head_handle), .out_vacant(out_vacant),
    .out_count(out_count),
    .outstanding(outstanding), .errors(errors)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Called at a rising edge; returns on the edge that accepts the transaction.
  task automatic send(func_e_t fn, logic [FIELD_BITS-1:0] h, logic [POS_BITS-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= fn;
    in_handle_in <= h;
    in_position  <= pos;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [FIELD_BITS-1:0] pick_handle();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return FIELD_BITS'($urandom);
  endfunction

  // fill_bias: 0 drains, 1 balanced, 2 fills toward full
  function automatic func_e_t pick_func(int fill_bias);
    int unsigned r;
    r = $urandom_range(99);
    case (fill_bias)
      0:       return (r < 10) ? FN_APPEND : (r < 20) ? FN_INSERT :
                      (r < 40) ? FN_READ : FN_REMOVE;
      2:       return (r < 40) ? FN_APPEND : (r < 80) ? FN_INSERT :
                      (r < 95) ? FN_READ : FN_REMOVE;
      default: return (r < 25) ? FN_APPEND : (r < 50) ? FN_INSERT :
                      (r < 75) ? FN_READ : FN_REMOVE;
    endcase
  endfunction

  initial begin
    int fill_bias;
    int n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue corner cases
    send(FN_REMOVE, 16'h0000, 4'd0);
    send(FN_READ,   16'h0000, 4'd0);
    send(FN_READ,   16'hFFFF, 4'd15);
    send(FN_APPEND, 16'hFFFF, 4'd0);
    send(FN_APPEND, 16'h0000, 4'd15);
    send(FN_INSERT, 16'h1234, 4'd0);   // new head
    send(FN_INSERT, 16'h5A5A, 4'd1);   // mid-queue shift
    send(FN_INSERT, 16'hA5A5, 4'd15);  // past the tail, appends
    send(FN_READ,   16'h0000, 4'd0);
    send(FN_READ,   16'h0000, 4'd4);
    send(FN_READ,   16'h0000, 4'd5);   // just past the tail
    repeat (11) send(FN_APPEND, pick_handle(), 4'($urandom));
    send(FN_APPEND, 16'hBEEF, 4'd0);   // rejected when full
    send(FN_INSERT, 16'hCAFE, 4'd0);
    send(FN_READ,   16'h0000, 4'd15);
    send(FN_REMOVE, 16'h0000, 4'd0);
    send(FN_INSERT, 16'h7777, 4'd0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 82; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 82; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      fill_bias = 1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 20 == 0) fill_bias = $urandom_range(2);
        send(pick_func(fill_bias), pick_handle(), 4'($urandom));
      end
    end

    in_valid <= 1'b0;
    stall_pct = 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ohq_pkg.sv
hdl/ohq_cell.sv
hdl/ordered_handle_queue.sv
test/ohq_checker.sv
test/tb_top.sv
